>>> rtl/vpts_pkg.sv
// ----------------------------------------------------------------------------
// Vertex projection package
// Shared constants, register indexes and request/response types of the
// vertex-to-screen projection block.
// ----------------------------------------------------------------------------
package vpts_pkg;

  // Default number of fraction bits of all fixed-point coordinates.
  localparam int unsigned FracBitsDef = 16;

  // |w| * NearZeroScale below one unit marks a degenerate w.
  localparam int unsigned NearZeroScale = 100000;

  // Configuration port geometry.
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 14;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgOriginX = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgOriginY = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgWidth   = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgHeight  = 2'd3;

  // Request command codes.
  localparam logic CmdLoad    = 1'b0;
  localparam logic CmdProject = 1'b1;

  // One request: a coefficient load or a point to project.
  typedef struct packed {
    logic               cmd;
    logic [4:0]         coef_slot;
    logic signed [31:0] coef_value;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
  } vpts_req_t;

  // One result: window position of a projected point.
  typedef struct packed {
    logic signed [15:0] screen_x;
    logic signed [15:0] screen_y;
    logic               degenerate;
  } vpts_rsp_t;

endpackage

>>> rtl/vertex_project_to_screen.sv
// ----------------------------------------------------------------------------
// Vertex projection to screen
// Model, projection and viewport mapping of a fixed-point point to pixels.
// ----------------------------------------------------------------------------
//  channel   | handshake                  | payload
//  ----------+----------------------------+---------------------------
//  request   | in_valid_i / in_ready_o    | in_req_i  (vpts_req_t)
//  response  | out_valid_o / out_ready_i  | out_rsp_o (vpts_rsp_t)
//  config    | cfg_we_i                   | cfg_idx_i, cfg_wdata_i
//
// One request enters every cycle while the output is not stalled; a point passes
// the request register, six arithmetic stages behind it, an 18-stage divider and
// the output register.
// Coefficient loads give no response and update the matrices in order.
// A stalled output freezes the whole pipeline; in_ready_o follows it.
// Reset clears valid bits and restores the viewport registers.
// ----------------------------------------------------------------------------
module vertex_project_to_screen
  import vpts_pkg::*;
#(
  parameter int unsigned FRAC_BITS = FracBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  vpts_req_t           in_req_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output vpts_rsp_t           out_rsp_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  localparam int unsigned NzLimit = ((1 << FRAC_BITS) + NearZeroScale - 1) / NearZeroScale;
  localparam logic signed [32:0] NzLim = 33'(NzLimit);
  localparam int unsigned QB = 18;       // quotient bits
  localparam int unsigned RW = 51;       // remainder width
  localparam int unsigned SW = QB + 4;   // final signed width

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return 32'sh7fffffff;
    if (v < -66'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [SW-1:0] v);
    if (v > SW'(32767)) return 16'sh7fff;
    if (v < -SW'(32768)) return 16'sh8000;
    return v[15:0];
  endfunction

  // Configuration registers.
  logic [12:0] org_x_q, org_y_q;
  logic [13:0] wid_q, hgt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      org_x_q <= '0;
      org_y_q <= '0;
      wid_q   <= 14'd640;
      hgt_q   <= 14'd480;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgOriginX: org_x_q <= cfg_wdata_i[12:0];
        CfgOriginY: org_y_q <= cfg_wdata_i[12:0];
        CfgWidth:   wid_q   <= cfg_wdata_i;
        CfgHeight:  hgt_q   <= cfg_wdata_i;
        default:    ;
      endcase
    end
  end

  // The whole pipeline moves when the output register can take a result.
  logic advance;
  logic out_valid_q;
  assign advance    = !out_valid_q || out_ready_i;
  assign in_ready_o = advance;

  // Stage 0: request register.
  logic      s0_vld_q;
  vpts_req_t s0_req_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s0_vld_q <= 1'b0;
    else if (advance) s0_vld_q <= in_valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_valid_i) s0_req_q <= in_req_i;
  end

  // Model matrix, written as a load leaves stage 0.
  logic signed [31:0] mm_q [16];

  always_ff @(posedge clk_i) begin
    if (advance && s0_vld_q && s0_req_q.cmd == CmdLoad && !s0_req_q.coef_slot[4]) begin
      mm_q[s0_req_q.coef_slot[3:0]] <= s0_req_q.coef_value;
    end
  end

  // Stage 1: model products for x, y and z; the w column passes as is.
  logic signed [31:0] s0_pt [3];
  logic signed [63:0] s1_prod_d [4][3];
  logic signed [63:0] s1_prod_q [4][3];
  logic signed [31:0] s1_bias_q [4];
  logic               s1_vld_q, s1_cmd_q;
  logic [4:0]         s1_slot_q;
  logic signed [31:0] s1_coef_q;

  assign s0_pt[0] = s0_req_q.point_x;
  assign s0_pt[1] = s0_req_q.point_y;
  assign s0_pt[2] = s0_req_q.point_z;

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 3; c++) begin
        s1_prod_d[r][c] = 64'(mm_q[c*4+r]) * 64'(s0_pt[c]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s1_vld_q <= 1'b0;
    else if (advance) s1_vld_q <= s0_vld_q;
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s1_prod_q <= s1_prod_d;
      for (int r = 0; r < 4; r++) s1_bias_q[r] <= mm_q[12+r];
      s1_cmd_q  <= s0_req_q.cmd;
      s1_slot_q <= s0_req_q.coef_slot;
      s1_coef_q <= s0_req_q.coef_value;
    end
  end

  // Stage 2: eye coordinates, floor-shifted sums saturated to 32 bits.
  logic signed [31:0] s2_eye_d [4];
  logic signed [31:0] s2_eye_q [4];
  logic               s2_vld_q, s2_cmd_q;
  logic [4:0]         s2_slot_q;
  logic signed [31:0] s2_coef_q;

  always_comb begin
    logic signed [65:0] acc;
    for (int r = 0; r < 4; r++) begin
      acc = 66'(s1_bias_q[r]);
      for (int c = 0; c < 3; c++) acc = acc + 66'(s1_prod_q[r][c] >>> FRAC_BITS);
      s2_eye_d[r] = sat32(acc);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s2_vld_q <= 1'b0;
    else if (advance) s2_vld_q <= s1_vld_q;
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s2_eye_q  <= s2_eye_d;
      s2_cmd_q  <= s1_cmd_q;
      s2_slot_q <= s1_slot_q;
      s2_coef_q <= s1_coef_q;
    end
  end

  // Projection matrix, written as a load leaves stage 2.
  logic signed [31:0] pm_q [16];

  always_ff @(posedge clk_i) begin
    if (advance && s2_vld_q && s2_cmd_q == CmdLoad && s2_slot_q[4]) begin
      pm_q[s2_slot_q[3:0]] <= s2_coef_q;
    end
  end

  // Stage 3: projection products for clip x, y and w (lane 2 is row 3).
  logic signed [63:0] s3_prod_d [3][4];
  logic signed [63:0] s3_prod_q [3][4];
  logic               s3_vld_q, s3_cmd_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      for (int c = 0; c < 4; c++) begin
        s3_prod_d[k][c] = 64'(pm_q[c*4 + ((k == 2) ? 3 : k)]) * 64'(s2_eye_q[c]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s3_vld_q <= 1'b0;
    else if (advance) s3_vld_q <= s2_vld_q;
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s3_prod_q <= s3_prod_d;
      s3_cmd_q  <= s2_cmd_q;
    end
  end

  // Stage 4: clip coordinates.
  logic signed [31:0] s4_clip_d [3];
  logic signed [31:0] s4_clip_q [3];
  logic               s4_vld_q, s4_cmd_q;

  always_comb begin
    logic signed [65:0] acc;
    for (int k = 0; k < 3; k++) begin
      acc = '0;
      for (int c = 0; c < 4; c++) acc = acc + 66'(s3_prod_q[k][c] >>> FRAC_BITS);
      s4_clip_d[k] = sat32(acc);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s4_vld_q <= 1'b0;
    else if (advance) s4_vld_q <= s3_vld_q;
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s4_clip_q <= s4_clip_d;
      s4_cmd_q  <= s3_cmd_q;
    end
  end

  // Stage 5: near-zero w test and viewport products of the numerators.
  logic [14:0]        k_x, k_y;
  logic signed [47:0] s5_pa_d [2];
  logic signed [46:0] s5_pb_d [2];
  logic signed [47:0] s5_pa_q [2];
  logic signed [46:0] s5_pb_q [2];
  logic signed [31:0] s5_w_q;
  logic               s5_deg_d, s5_deg_q;
  logic               s5_vld_q, s5_cmd_q;

  assign k_x = 15'({org_x_q, 1'b1}) + 15'(wid_q);
  assign k_y = 15'({org_y_q, 1'b1}) + 15'(hgt_q);

  assign s5_pa_d[0] = 48'(s4_clip_q[2]) * 48'($signed({1'b0, k_x}));
  assign s5_pa_d[1] = 48'(s4_clip_q[2]) * 48'($signed({1'b0, k_y}));
  assign s5_pb_d[0] = 47'(s4_clip_q[0]) * 47'($signed({1'b0, wid_q}));
  assign s5_pb_d[1] = 47'(s4_clip_q[1]) * 47'($signed({1'b0, hgt_q}));
  assign s5_deg_d   = (33'(s4_clip_q[2]) > -NzLim) && (33'(s4_clip_q[2]) < NzLim);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s5_vld_q <= 1'b0;
    else if (advance) s5_vld_q <= s4_vld_q;
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s5_pa_q  <= s5_pa_d;
      s5_pb_q  <= s5_pb_d;
      s5_w_q   <= s4_clip_q[2];
      s5_deg_q <= s5_deg_d;
      s5_cmd_q <= s4_cmd_q;
    end
  end

  // Stage 6: numerator sums, magnitudes and quotient signs.
  logic signed [48:0] s6_n   [2];
  logic [48:0]        s6_mag [2];
  logic signed [32:0] s6_w2;
  logic [RW-1:0]      s6_r_q [2];
  logic               s6_neg_q [2];
  logic [32:0]        s6_d_q;
  logic               s6_deg_q, s6_vld_q, s6_cmd_q;

  assign s6_w2 = {s5_w_q, 1'b0};

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      s6_n[a]   = 49'(s5_pa_q[a]) + 49'(s5_pb_q[a]);
      s6_mag[a] = s6_n[a][48] ? 49'(-s6_n[a]) : 49'(s6_n[a]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s6_vld_q <= 1'b0;
    else if (advance) s6_vld_q <= s5_vld_q;
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      for (int a = 0; a < 2; a++) begin
        s6_r_q[a]   <= RW'(s6_mag[a]);
        s6_neg_q[a] <= s6_n[a][48] ^ s5_w_q[31];
      end
      s6_d_q   <= s6_w2[32] ? 33'(-s6_w2) : 33'(s6_w2);
      s6_deg_q <= s5_deg_q;
      s6_cmd_q <= s5_cmd_q;
    end
  end

  // Restoring divider: one quotient bit per stage for both axes.
  logic [RW-1:0] dv_r_q   [QB][2];
  logic [QB-1:0] dv_quo_q [QB][2];
  logic          dv_neg_q [QB][2];
  logic          dv_ovf_q [QB][2];
  logic [32:0]   dv_d_q   [QB];
  logic          dv_vld_q [QB];
  logic          dv_cmd_q [QB];
  logic          dv_deg_q [QB];

  for (genvar k = 0; k < QB; k++) begin : g_div
    logic [RW-1:0] r_in [2];
    logic [QB-1:0] q_in [2];
    logic          neg_in [2];
    logic          ovf_in [2];
    logic [32:0]   d_in;
    logic          vld_in, cmd_in, deg_in;
    logic [RW-1:0] dsh;
    logic          ge [2];

    if (k == 0) begin : g_first
      for (genvar a = 0; a < 2; a++) begin : g_ax
        assign r_in[a]   = s6_r_q[a];
        assign q_in[a]   = '0;
        assign neg_in[a] = s6_neg_q[a];
        assign ovf_in[a] = s6_r_q[a] >= (RW'(s6_d_q) << QB);
      end
      assign d_in   = s6_d_q;
      assign vld_in = s6_vld_q;
      assign cmd_in = s6_cmd_q;
      assign deg_in = s6_deg_q;
    end else begin : g_next
      for (genvar a = 0; a < 2; a++) begin : g_ax
        assign r_in[a]   = dv_r_q[k-1][a];
        assign q_in[a]   = dv_quo_q[k-1][a];
        assign neg_in[a] = dv_neg_q[k-1][a];
        assign ovf_in[a] = dv_ovf_q[k-1][a];
      end
      assign d_in   = dv_d_q[k-1];
      assign vld_in = dv_vld_q[k-1];
      assign cmd_in = dv_cmd_q[k-1];
      assign deg_in = dv_deg_q[k-1];
    end

    assign dsh   = RW'(d_in) << (QB - 1 - k);
    assign ge[0] = r_in[0] >= dsh;
    assign ge[1] = r_in[1] >= dsh;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) dv_vld_q[k] <= 1'b0;
      else if (advance) dv_vld_q[k] <= vld_in;
    end

    always_ff @(posedge clk_i) begin
      if (advance) begin
        for (int a = 0; a < 2; a++) begin
          dv_r_q[k][a]   <= ge[a] ? r_in[a] - dsh : r_in[a];
          dv_quo_q[k][a] <= q_in[a] | (QB'(ge[a]) << (QB - 1 - k));
          dv_neg_q[k][a] <= neg_in[a];
          dv_ovf_q[k][a] <= ovf_in[a];
        end
        dv_d_q[k]   <= d_in;
        dv_cmd_q[k] <= cmd_in;
        dv_deg_q[k] <= deg_in;
      end
    end
  end

  // Final stage: signed quotient, y flip, saturation and output register.
  logic [QB:0]          q_mag [2];
  logic signed [SW-1:0] q_s   [2];
  vpts_rsp_t            rsp_d, out_rsp_q;

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      q_mag[a] = dv_ovf_q[QB-1][a] ? (QB+1)'(1 << QB) : {1'b0, dv_quo_q[QB-1][a]};
      q_s[a]   = dv_neg_q[QB-1][a] ? -$signed(SW'(q_mag[a])) : $signed(SW'(q_mag[a]));
    end
    if (dv_deg_q[QB-1]) begin
      rsp_d.screen_x   = '0;
      rsp_d.screen_y   = '0;
      rsp_d.degenerate = 1'b1;
    end else begin
      rsp_d.screen_x   = sat16(q_s[0]);
      rsp_d.screen_y   = sat16($signed(SW'(hgt_q)) - q_s[1]);
      rsp_d.degenerate = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (advance) out_valid_q <= dv_vld_q[QB-1] && dv_cmd_q[QB-1] == CmdProject;
  end

  always_ff @(posedge clk_i) begin
    if (advance) out_rsp_q <= rsp_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

endmodule

>>> rtl/vpts_checker.sv
// ----------------------------------------------------------------------------
// Vertex projection port checker
// Port-level checks of the projection block, bound to its top level.
// ----------------------------------------------------------------------------
module vpts_checker
  import vpts_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_ready_o,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input vpts_rsp_t out_rsp_o
);

  // A response that is not taken stays, unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_rsp_o))
    else $error("response dropped or changed while stalled");

  // The request side only stalls when the output is blocked.
  a_ready_tie: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o == (!out_valid_o || out_ready_i))
    else $error("request ready does not follow output stall");

  // A degenerate w always reports the origin.
  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.degenerate |-> out_rsp_o.screen_x == '0 &&
    out_rsp_o.screen_y == '0)
    else $error("degenerate response with nonzero position");

  // No response appears in the cycle after reset releases.
  a_reset_quiet: assert property (@(posedge clk_i)
    !$past(rst_ni) |-> !out_valid_o)
    else $error("response right after reset");

endmodule

bind vertex_project_to_screen vpts_checker u_vpts_checker (.*);
